>>> sv/dda_line_rasterizer_core_assert.svh
// assertion macros for the dda line rasterizer
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define DLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define DLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dlr_pkg.sv
// shared types and codes for the dda line rasterizer
`timescale 1ns / 1ps

package dlr_pkg;

    localparam int COLOR_BITS = 24;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> sv/dda_line_rasterizer_core.sv
// dda line rasterizer: a start request emits the first pixel in the next cycle; then,
// unless the line has zero length, the block is busy while one shared
// bit-serial divider works out the x and then the y increment.
// step requests run one per cycle into the output register while idle and not stalled.
// reset is synchronous, active low: idle, no line active, output empty.
`timescale 1ns / 1ps

`include "dda_line_rasterizer_core_assert.svh"

module dda_line_rasterizer_core
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // start_x, start_y, end_x, end_y, line_color, zero padding
    input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero padding
    output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    // last_pixel
    output logic                m_axis_tlast
);

    localparam int ACC_W  = COORD_BITS + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 2;

    t_state                r_state, n_state;
    logic                  r_active, n_active;
    logic [ACC_W-1:0]      r_acc_x, n_acc_x;
    logic [ACC_W-1:0]      r_acc_y, n_acc_y;
    logic [STEP_W-1:0]     r_step_x, n_step_x;
    logic [STEP_W-1:0]     r_step_y, n_step_y;
    logic [COORD_BITS-1:0] r_left, n_left;
    logic [COLOR_BITS-1:0] r_color, n_color;
    logic [COORD_BITS-1:0] r_ady, n_ady;
    logic [COORD_BITS-1:0] r_steps, n_steps;
    logic                  r_neg_x, n_neg_x;
    logic                  r_neg_y, n_neg_y;
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_x, n_out_x;
    logic [COORD_BITS-1:0] r_out_y, n_out_y;
    logic                  r_out_last, n_out_last;

    logic                  w_accept;
    logic [COORD_BITS-1:0] w_sx, w_sy, w_ex, w_ey;
    logic [COORD_BITS-1:0] w_adx, w_ady, w_steps;
    logic [ACC_W-1:0]      w_next_x, w_next_y;
    logic [STEP_W-1:0]     w_step_mag, w_step_val;
    logic [COORD_BITS-1:0] w_left_dec;

    logic                  w_div_start;
    logic [COORD_BITS-1:0] w_div_num, w_div_den;
    logic [FRAC_BITS:0]    w_quo;
    t_div_stat             w_div_stat;

    dlr_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_quo  (w_quo),
        .o_stat (w_div_stat)
    );

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_sx = s_axis_tdata[COORD_BITS-1:0];
        w_sy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        w_ex = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
        w_ey = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
        w_adx   = (w_ex >= w_sx) ? w_ex - w_sx : w_sx - w_ex;
        w_ady   = (w_ey >= w_sy) ? w_ey - w_sy : w_sy - w_ey;
        w_steps = (w_adx > w_ady) ? w_adx : w_ady;
        w_next_x = r_acc_x + {{(ACC_W-STEP_W){r_step_x[STEP_W-1]}}, r_step_x};
        w_next_y = r_acc_y + {{(ACC_W-STEP_W){r_step_y[STEP_W-1]}}, r_step_y};
        w_left_dec = r_left - 1'b1;
        // apply the axis sign to the quotient magnitude
        w_step_mag = {1'b0, w_quo};
        if ((r_state == ST_DIV_X) ? r_neg_x : r_neg_y) begin
            w_step_val = -w_step_mag;
        end else begin
            w_step_val = w_step_mag;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_step_x    = r_step_x;
        n_step_y    = r_step_y;
        n_left      = r_left;
        n_color     = r_color;
        n_ady       = r_ady;
        n_steps     = r_steps;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        w_div_start = 1'b0;
        w_div_num   = r_ady;
        w_div_den   = r_steps;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == REQ_START) begin
                        n_color     = s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
                        n_acc_x     = {w_sx, {FRAC_BITS{1'b0}}};
                        n_acc_y     = {w_sy, {FRAC_BITS{1'b0}}};
                        n_out_valid = 1'b1;
                        n_out_x     = w_sx;
                        n_out_y     = w_sy;
                        if (w_steps == '0) begin
                            // zero-length line: a single pixel, stays idle
                            n_step_x   = '0;
                            n_step_y   = '0;
                            n_left     = '0;
                            n_active   = 1'b0;
                            n_out_last = 1'b1;
                        end else begin
                            n_left      = w_steps;
                            n_active    = 1'b1;
                            n_out_last  = 1'b0;
                            n_ady       = w_ady;
                            n_steps     = w_steps;
                            n_neg_x     = w_ex < w_sx;
                            n_neg_y     = w_ey < w_sy;
                            w_div_start = 1'b1;
                            w_div_num   = w_adx;
                            w_div_den   = w_steps;
                            n_state     = ST_DIV_X;
                        end
                    end else if (r_active) begin
                        n_acc_x     = w_next_x;
                        n_acc_y     = w_next_y;
                        n_left      = w_left_dec;
                        n_active    = w_left_dec != '0;
                        n_out_valid = 1'b1;
                        n_out_x     = w_next_x[ACC_W-1:FRAC_BITS];
                        n_out_y     = w_next_y[ACC_W-1:FRAC_BITS];
                        n_out_last  = w_left_dec == '0;
                    end
                end
            end
            ST_DIV_X: begin
                if (w_div_stat.done) begin
                    n_step_x    = w_step_val;
                    w_div_start = 1'b1;
                    n_state     = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (w_div_stat.done) begin
                    n_step_y = w_step_val;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_x    <= n_acc_x;
        r_acc_y    <= n_acc_y;
        r_step_x   <= n_step_x;
        r_step_y   <= n_step_y;
        r_left     <= n_left;
        r_color    <= n_color;
        r_ady      <= n_ady;
        r_steps    <= n_steps;
        r_neg_x    <= n_neg_x;
        r_neg_y    <= n_neg_y;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[COORD_BITS-1:0]            = r_out_x;
        m_axis_tdata[2*COORD_BITS-1:COORD_BITS] = r_out_y;
        m_axis_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS] = r_color;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;

    `DLR_ASSERT_NOW(a_done_in_div, w_div_stat.done, (r_state == ST_DIV_X || r_state == ST_DIV_Y), "divider finished outside a divide state")
    `DLR_ASSERT_NOW(a_idle_div_free, (r_state == ST_IDLE), !w_div_stat.busy, "divider busy while idle")
    `DLR_ASSERT_NOW(a_active_left, r_active, (r_left != '0), "active line with no pixels left")
    `DLR_ASSERT_NEXT(a_start_busy, (w_accept && s_axis_tuser == REQ_START && r_state == ST_IDLE && w_steps != '0), (w_div_stat.busy && r_state == ST_DIV_X), "start did not launch the divider")

endmodule

>>> sv/dlr_div.sv
// restoring divider, one quotient bit per cycle, for the per-axis increment
`timescale 1ns / 1ps

module dlr_div
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_num,
    input  logic [COORD_BITS-1:0] i_den,
    output logic [FRAC_BITS:0]    o_quo,
    output t_div_stat             o_stat
);

    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [COORD_BITS-1:0] r_rem;
    logic [COORD_BITS-1:0] r_den;
    logic [FRAC_BITS:0]    r_num;
    logic [FRAC_BITS:0]    r_quo;

    logic [COORD_BITS:0]   w_trial;
    logic [COORD_BITS:0]   w_diff;
    logic                  w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[FRAC_BITS]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS + 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient fits frac+1 bits since |d| <= steps, so the top of the
    // dividend starts in the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[COORD_BITS-1:1]};
            r_num <= {i_num[0], {FRAC_BITS{1'b0}}};
            r_quo <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[COORD_BITS-1:0] : w_trial[COORD_BITS-1:0];
            r_num <= {r_num[FRAC_BITS-1:0], 1'b0};
            r_quo <= {r_quo[FRAC_BITS-1:0], w_ge};
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> tb/sv/tb_dda_line_rasterizer_core.sv
// self-checking testbench for the dda line rasterizer core with a built-in pixel predictor
`timescale 1ns / 1ps

module tb_dda_line_rasterizer_core;
    import dlr_pkg::*;

    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_BITS     = FRAC_BITS + 2;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_RUN      = 60;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t                x;
        coord_t                y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    logic                                      i_clk;
    logic                                      i_rst_n = 1'b0;
    logic                                      s_axis_tvalid = 1'b0;
    logic                                      s_axis_tready;
    // start_x, start_y, end_x, end_y, line_color
    logic [4*COORD_BITS+COLOR_BITS-1:0]        s_axis_tdata = '0;
    // req_type
    logic                                      s_axis_tuser = REQ_STEP;
    logic                                      m_axis_tvalid;
    logic                                      m_axis_tready = 1'b0;
    // pixel_x, pixel_y, pixel_color
    logic [2*COORD_BITS+COLOR_BITS-1:0]        m_axis_tdata;
    logic                                      m_axis_tlast;

    // predictor state of the line being drawn
    logic [ACC_BITS-1:0]   pen_x, pen_y;
    logic [INC_BITS-1:0]   inc_x, inc_y;
    logic [COORD_BITS:0]   pixels_to_go;
    logic [COLOR_BITS-1:0] pen_color;
    logic                  drawing;

    pixel_t pixel_q[$];
    int     pixels_predicted = 0;
    int     error_count = 0;
    int     src_idle_pct = 0;
    int     sink_stall_pct = 0;
    logic   hold_on = 1'b0;
    event   hold_start;

    dda_line_rasterizer_core #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("dda_line_rasterizer_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
        error_count++;
    endtask

    // signed per-axis increment, magnitude truncated toward zero
    function automatic logic [INC_BITS-1:0] axis_inc(input coord_t s, input coord_t e,
                                                     input coord_t span);
        coord_t                         gap;
        logic [COORD_BITS+FRAC_BITS-1:0] mag;
        gap = (s > e) ? s - e : e - s;
        mag = {gap, {FRAC_BITS{1'b0}}} / span;
        return (e >= s) ? mag[INC_BITS-1:0] : -mag[INC_BITS-1:0];
    endfunction

    task automatic push_pixel(input logic last);
        pixel_t p;
        p.x     = pen_x[FRAC_BITS +: COORD_BITS];
        p.y     = pen_y[FRAC_BITS +: COORD_BITS];
        p.color = pen_color;
        p.last  = last;
        pixel_q.push_back(p);
        pixels_predicted++;
    endtask

    task automatic trace_line(input logic rtype, input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey,
                              input logic [COLOR_BITS-1:0] col);
        coord_t adx, ady, span;
        if (rtype == REQ_START) begin
            adx       = (sx > ex) ? sx - ex : ex - sx;
            ady       = (sy > ey) ? sy - ey : ey - sy;
            span      = (adx > ady) ? adx : ady;
            pen_color = col;
            pen_x     = {1'b0, sx, {FRAC_BITS{1'b0}}};
            pen_y     = {1'b0, sy, {FRAC_BITS{1'b0}}};
            if (span == 0) begin
                inc_x        = '0;
                inc_y        = '0;
                pixels_to_go = '0;
                drawing      = 1'b0;
                push_pixel(1'b1);
            end else begin
                inc_x        = axis_inc(sx, ex, span);
                inc_y        = axis_inc(sy, ey, span);
                pixels_to_go = {1'b0, span};
                drawing      = 1'b1;
                push_pixel(1'b0);
            end
        end else if (drawing) begin
            pen_x        = pen_x + {{(ACC_BITS-INC_BITS){inc_x[INC_BITS-1]}}, inc_x};
            pen_y        = pen_y + {{(ACC_BITS-INC_BITS){inc_y[INC_BITS-1]}}, inc_y};
            pixels_to_go = pixels_to_go - 1'b1;
            drawing      = (pixels_to_go != 0);
            push_pixel(!drawing);
        end
    endtask

    // one request: optional idle gap, then hold until accepted
    task automatic send_req(input logic rtype, input coord_t sx, input coord_t sy,
                            input coord_t ex, input coord_t ey,
                            input logic [COLOR_BITS-1:0] col);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= (4*COORD_BITS+COLOR_BITS)'({$urandom, $urandom, $urandom});
            s_axis_tuser  <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rtype;
        s_axis_tdata  <= {col, ey, ex, sy, sx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        trace_line(rtype, sx, sy, ex, ey, col);
    endtask

    // step requests carry random payload the block must ignore
    task automatic step_req();
        send_req(REQ_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), COLOR_BITS'($urandom));
    endtask

    task automatic draw_random_line();
        int sx, sy, ex, ey, reach, span, n_steps, roll;
        sx = $urandom_range(COORD_MAX);
        sy = $urandom_range(COORD_MAX);
        if ($urandom_range(9) == 0) sx = $urandom_range(1) ? COORD_MAX : 0;
        if ($urandom_range(9) == 0) sy = $urandom_range(1) ? COORD_MAX : 0;
        roll = $urandom_range(99);
        if (roll < 4) begin
            ex = $urandom_range(COORD_MAX);
            ey = $urandom_range(COORD_MAX);
        end else begin
            reach = (roll < 12) ? 200 : 12;
            ex = sx + $urandom_range(2 * reach) - reach;
            ey = sy + $urandom_range(2 * reach) - reach;
            if (ex < 0) ex = 0;
            if (ex > COORD_MAX) ex = COORD_MAX;
            if (ey < 0) ey = 0;
            if (ey > COORD_MAX) ey = COORD_MAX;
        end
        span = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > span) span = (ey > sy) ? ey - sy : sy - ey;
        roll = $urandom_range(99);
        if (roll < 70)      n_steps = span;
        else if (roll < 85) n_steps = span + $urandom_range(1, 2);
        else                n_steps = $urandom_range(span);
        // long lines get cut short and restarted by the next start
        if (n_steps > MAX_RUN) n_steps = $urandom_range(MAX_RUN);
        send_req(REQ_START, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
                 COLOR_BITS'($urandom));
        repeat (n_steps) step_req();
    endtask

    task automatic draw_lines(input int n_pixels);
        int target;
        target = pixels_predicted + n_pixels;
        while (pixels_predicted < target) draw_random_line();
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // step with no line running
        step_req();
        // zero-length lines at both corners
        send_req(REQ_START, 0, 0, 0, 0, 24'h000000);
        send_req(REQ_START, coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
                 coord_t'(COORD_MAX), 24'hFFFFFF);
        // full diagonal, cut short by a new start
        send_req(REQ_START, 0, coord_t'(COORD_MAX), coord_t'(COORD_MAX), 0, 24'hA5A5A5);
        repeat (3) step_req();
        send_req(REQ_START, coord_t'(COORD_MAX), 0, coord_t'(COORD_MAX - 3), 2, 24'h5A5A5A);
        repeat (3) step_req();
        step_req();
        // inexact ratio on y
        send_req(REQ_START, 0, 0, 3, 2, 24'h123456);
        repeat (3) step_req();
        // vertical line going up, then one step past its end
        send_req(REQ_START, 7, 3000, 7, 2995, 24'h0F0F0F);
        repeat (6) step_req();
    endtask

    task automatic test_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        draw_lines(400);
    endtask

    task automatic test_sender_idle();
        src_idle_pct   = 83;
        sink_stall_pct = 0;
        draw_lines(400);
    endtask

    task automatic test_receiver_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 83;
        draw_lines(400);
    endtask

    task automatic test_both_idle();
        src_idle_pct   = 13;
        sink_stall_pct = 13;
        draw_lines(380);
    endtask

    // output held off while steps keep coming, so the input has to stall
    task automatic test_output_hold();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_req(REQ_START, 100, 100, 180, 130, 24'hC0FFEE);
        -> hold_start;
        repeat (60) step_req();
    endtask

    initial begin
        forever begin
            @(hold_start);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !hold_on && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : pixel_check
        pixel_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch("pixel with no request pending", 0, m_axis_tdata);
            end else begin
                want = pixel_q.pop_front();
                if (m_axis_tdata[0 +: COORD_BITS] !== want.x)
                    report_mismatch("pixel_x", want.x, m_axis_tdata[0 +: COORD_BITS]);
                if (m_axis_tdata[COORD_BITS +: COORD_BITS] !== want.y)
                    report_mismatch("pixel_y", want.y, m_axis_tdata[COORD_BITS +: COORD_BITS]);
                if (m_axis_tdata[2*COORD_BITS +: COLOR_BITS] !== want.color)
                    report_mismatch("pixel_color", want.color,
                                    m_axis_tdata[2*COORD_BITS +: COLOR_BITS]);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_pixel", want.last, m_axis_tlast);
            end
        end
    end

    initial begin
        pen_x        = '0;
        pen_y        = '0;
        inc_x        = '0;
        inc_y        = '0;
        pixels_to_go = '0;
        pen_color    = '0;
        drawing      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_output_hold();

        s_axis_tvalid <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("dda_line_rasterizer_core verification clean");
        end else begin
            $display("dda_line_rasterizer_core verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/dlr_pkg.sv
sv/dlr_div.sv
sv/dda_line_rasterizer_core.sv
tb/sv/tb_dda_line_rasterizer_core.sv
